[rtl/core/ffd_pkg.sv]
// shared constants, codes and types of the flooding duplicate filter
// no dependencies; compiled first
package ffd_pkg;

  // ring geometry
  localparam int RING_END     = 99;
  localparam int RING_RESTART = 10;
  localparam int IDX_W        = $clog2(RING_END);
  localparam int PTR_W        = $clog2(RING_END + 1);

  // header field widths
  localparam int BYTE_W  = 8;
  localparam int IDENT_W = 3 * BYTE_W;
  localparam int ACT_W   = 2;

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_OWN_ADDRESS = 2'd0;

  // action codes of a result
  localparam logic [ACT_W-1:0] ACT_DROP     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELIVER  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK_RCVD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FORWARD  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ffd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_addr;
    logic out_free;
  } ffd_status_t;

endpackage

[rtl/core/ffd_if.sv]
// request channels of the duplicate filter: header in, result out
// depends on ffd_pkg
interface ffd_in_if;
  import ffd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] dest_address;
  logic [BYTE_W-1:0] src_address;
  logic [BYTE_W-1:0] seq_high_byte;
  logic [BYTE_W-1:0] seq_low_byte;
  logic              is_ack;

  modport source (output valid, dest_address, src_address, seq_high_byte,
                  seq_low_byte, is_ack, input ready);
  modport sink (input valid, dest_address, src_address, seq_high_byte,
                seq_low_byte, is_ack, output ready);
endinterface

interface ffd_out_if;
  import ffd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] out_dest;
  logic [BYTE_W-1:0] out_src;
  logic              out_is_ack;

  modport source (output valid, action, out_dest, out_src, out_is_ack,
                  input ready);
  modport sink (input valid, action, out_dest, out_src, out_is_ack,
                output ready);
endinterface

[rtl/core/ffd_ctrl.sv]
// controller: sequences load, ring scan and commit of one request
// depends on ffd_pkg
module ffd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ffd_pkg::ffd_status_t  status,
  output ffd_pkg::ffd_cmd_t     cmd
);
  import ffd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.last_addr) state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_LAST: begin
      end
      ST_DECIDE: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/ffd_datapath.sv]
// datapath: header register, two seen rings with scan compare, result register
// depends on ffd_pkg
module ffd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ffd_pkg::ffd_cmd_t             cmd,
  output ffd_pkg::ffd_status_t          status,
  input  logic [ffd_pkg::BYTE_W-1:0]    own_address,
  input  logic [ffd_pkg::BYTE_W-1:0]    dest_address,
  input  logic [ffd_pkg::BYTE_W-1:0]    src_address,
  input  logic [ffd_pkg::BYTE_W-1:0]    seq_high_byte,
  input  logic [ffd_pkg::BYTE_W-1:0]    seq_low_byte,
  input  logic                          is_ack,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffd_pkg::ACT_W-1:0]     action,
  output logic [ffd_pkg::BYTE_W-1:0]    out_dest,
  output logic [ffd_pkg::BYTE_W-1:0]    out_src,
  output logic                          out_is_ack
);
  import ffd_pkg::*;

  // held header
  logic [BYTE_W-1:0]  hdr_dest;
  logic [BYTE_W-1:0]  hdr_src;
  logic [IDENT_W-1:0] hdr_ident;
  logic               hdr_ack;

  // rings
  logic [IDENT_W-1:0] data_mem [RING_END];
  logic [IDENT_W-1:0] ack_mem  [RING_END];
  logic [RING_END-1:0] data_valid;
  logic [RING_END-1:0] ack_valid;
  logic [PTR_W-1:0]   data_ptr;
  logic [PTR_W-1:0]   ack_ptr;

  // scan
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_pend;
  logic               rd_vld;
  logic [IDENT_W-1:0] rd_data;
  logic               hit;

  // decision
  logic               to_me;
  logic               from_me;
  logic               record;
  logic [PTR_W-1:0]   ring_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [ACT_W-1:0]   action_next;
  logic [BYTE_W-1:0]  out_dest_next;
  logic [BYTE_W-1:0]  out_src_next;
  logic               out_is_ack_next;

  // header capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr_dest  <= dest_address;
      hdr_src   <= src_address;
      hdr_ident <= {src_address, seq_high_byte, seq_low_byte};
      hdr_ack   <= is_ack;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // registered ring read at the scan address
  always_ff @(posedge clk) begin
    if (hdr_ack) begin
      rd_data <= ack_mem[scan_idx];
      rd_vld  <= ack_valid[scan_idx];
    end else begin
      rd_data <= data_mem[scan_idx];
      rd_vld  <= data_valid[scan_idx];
    end
  end

  // match accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit     <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (rd_pend && rd_vld && (rd_data == hdr_ident)) begin
        hit <= 1'b1;
      end
    end
  end

  // routing decision
  always_comb begin
    to_me           = (hdr_dest == own_address);
    from_me         = (hdr_src == own_address);
    record          = !hit && (to_me || !from_me);
    action_next     = ACT_DROP;
    out_dest_next   = '0;
    out_src_next    = '0;
    out_is_ack_next = 1'b0;
    if (!hit) begin
      if (to_me) begin
        if (!hdr_ack) begin
          action_next     = ACT_DELIVER;
          out_dest_next   = hdr_src;
          out_src_next    = hdr_dest;
          out_is_ack_next = 1'b1;
        end else begin
          action_next = ACT_ACK_RCVD;
        end
      end else if (!from_me) begin
        action_next     = ACT_FORWARD;
        out_dest_next   = hdr_dest;
        out_src_next    = hdr_src;
        out_is_ack_next = hdr_ack;
      end
    end
  end

  // write pointer with wrap back to the restart entry
  always_comb begin
    ring_ptr = hdr_ack ? ack_ptr : data_ptr;
    wr_ptr   = (ring_ptr >= PTR_W'(RING_END)) ? PTR_W'(RING_RESTART) : ring_ptr;
  end

  // ring contents
  always_ff @(posedge clk) begin
    if (cmd.commit && record) begin
      if (hdr_ack) begin
        ack_mem[wr_ptr[IDX_W-1:0]] <= hdr_ident;
      end else begin
        data_mem[wr_ptr[IDX_W-1:0]] <= hdr_ident;
      end
    end
  end

  // valid bits and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= '0;
      ack_valid  <= '0;
      data_ptr   <= '0;
      ack_ptr    <= '0;
    end else if (cmd.commit && record) begin
      if (hdr_ack) begin
        ack_valid[wr_ptr[IDX_W-1:0]] <= 1'b1;
        ack_ptr <= wr_ptr + PTR_W'(1);
      end else begin
        data_valid[wr_ptr[IDX_W-1:0]] <= 1'b1;
        data_ptr <= wr_ptr + PTR_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action     <= action_next;
      out_dest   <= out_dest_next;
      out_src    <= out_src_next;
      out_is_ack <= out_is_ack_next;
    end
  end

  // status
  assign status.last_addr = (scan_idx == IDX_W'(RING_END - 1));
  assign status.out_free  = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (data_ptr <= PTR_W'(RING_END)) && (ack_ptr <= PTR_W'(RING_END)))
    else $error("ring pointer beyond ring end");

  a_no_scan_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan && cmd.commit) && !(cmd.load && cmd.scan))
    else $error("overlapping controller commands");
`endif

endmodule

[rtl/core/flood_forward_dedup.sv]
// top level of the flooding duplicate filter: APB register, controller, datapath
// depends on ffd_pkg, ffd_if, ffd_ctrl and ffd_datapath
// requests are taken one at a time, in the idle state only; each is scanned against
//   the 99 ring entries through one registered read port, one entry per cycle, and its
//   result is registered at commit, which waits until the previous result is taken
// reset: synchronous; both rings empty and pointers zero at once (valid bits
//   in flip-flops, no clearing pass), own_address zero, result channel empty
module flood_forward_dedup (
  input  logic                        clk,
  input  logic                        rst,
  ffd_in_if.sink                      in_ch,
  ffd_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffd_pkg::PADDR_W-1:0] paddr,
  input  logic [ffd_pkg::PDATA_W-1:0] pwdata,
  output logic [ffd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ffd_pkg::*;

  logic [BYTE_W-1:0] own_address;
  ffd_cmd_t          cmd;
  ffd_status_t       status;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && (paddr == REG_OWN_ADDRESS)) begin
      own_address <= pwdata[BYTE_W-1:0];
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_OWN_ADDRESS) begin
      prdata = PDATA_W'(own_address);
    end
  end

  assign pready = 1'b1;

  // control sequencer
  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // rings and decision
  ffd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .own_address   (own_address),
    .dest_address  (in_ch.dest_address),
    .src_address   (in_ch.src_address),
    .seq_high_byte (in_ch.seq_high_byte),
    .seq_low_byte  (in_ch.seq_low_byte),
    .is_ack        (in_ch.is_ack),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .action        (out_ch.action),
    .out_dest      (out_ch.out_dest),
    .out_src       (out_ch.out_src),
    .out_is_ack    (out_ch.out_is_ack)
  );

endmodule
